@@ rtl/core/fsca_pkg.sv @@
// Shared types and constants for the sector chain allocator.
// No dependencies; imported by every other file of the block but fsca_ram.
`timescale 1ns / 1ps

package fsca_pkg;

   // command codes on req_kind
   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_BEGIN = 3'd1;
   localparam logic [2:0] KIND_CONT  = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;
   localparam logic [2:0] KIND_SUM   = 3'd5;

   // register map (index = paddr[2])
   localparam logic REG_DATA_START  = 1'b0;
   localparam logic REG_ENTRIES_USE = 1'b1;

   localparam int KIND_W     = 3;
   localparam int INDEX_W    = 11;
   localparam int ENTRY_W    = 16;
   localparam int LENGTH_W   = 11;
   localparam int SECTOR_W   = 11;
   localparam int SUM_W      = 8;
   localparam int START_W    = 11;
   localparam int LIMIT_W    = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ENTRY_W-1:0] USED_BIT  = 16'h8000;
   localparam logic [ENTRY_W-1:0] LINK_BITS = 16'hC000;

   localparam logic [START_W-1:0] START_RESET = 11'd128;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic load_start;
      logic load_one;
      logic scan_run;
      logic acc_sum;
      logic skip_cur;
      logic do_write;
      logic do_mark;
      logic do_link;
      logic take_hit;
      logic rd_index;
      logic rd_zero;
      logic store_sum;
      logic finish;
      logic res_full;
      logic res_entry;
      logic res_sum;
   } fsca_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic hit;
      logic done;
   } fsca_stat_type;

endpackage

@@ rtl/core/fsca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fsca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fsca_ctrl.sv @@
// Command sequencer for the sector chain allocator.
// Depends on fsca_pkg; drives fsca_dpath through fsca_cmd_type.
`timescale 1ns / 1ps

module fsca_ctrl import fsca_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KIND_W-1:0]   req_kind,
   input  fsca_stat_type       stat,
   output fsca_cmd_type        cmd,
   output logic                busy
);

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_SCAN1  = 9'b000000100,
      ST_SCAN2  = 9'b000001000,
      ST_SUM    = 9'b000010000,
      ST_RD0    = 9'b000100000,
      ST_WR0    = 9'b001000000,
      ST_RDDATA = 9'b010000000,
      ST_DONE   = 9'b100000000
   } fsca_state_type;

   fsca_state_type state_ff, state_in;
   logic           cont_ff, cont_in;

   always_comb begin
      state_in = state_ff;
      cont_in  = cont_ff;
      cmd      = '0;
      cmd.skip_cur = cont_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               cont_in    = (req_kind == KIND_CONT);
               case (req_kind)
                  KIND_WRITE: begin
                     cmd.do_write = 1'b1;
                     state_in     = ST_DONE;
                  end
                  KIND_BEGIN, KIND_CONT: begin
                     cmd.load_start = 1'b1;
                     state_in       = ST_SCAN1;
                  end
                  KIND_END: begin
                     cmd.do_mark = 1'b1;
                     state_in    = ST_DONE;
                  end
                  KIND_READ: begin
                     cmd.rd_index = 1'b1;
                     state_in     = ST_RDDATA;
                  end
                  KIND_SUM: begin
                     cmd.load_one = 1'b1;
                     state_in     = ST_SUM;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN1, ST_SCAN2: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               cmd.do_link  = cont_ff;
               cmd.finish   = 1'b1;
               state_in     = ST_IDLE;
            end else if (stat.done) begin
               if (state_ff == ST_SCAN1) begin
                  // retry from entry 1
                  cmd.load_one = 1'b1;
                  state_in     = ST_SCAN2;
               end else begin
                  cmd.res_full = 1'b1;
                  cmd.finish   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_SUM: begin
            cmd.acc_sum = 1'b1;
            if (stat.done) begin
               state_in = ST_RD0;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_RD0: begin
            cmd.rd_zero = 1'b1;
            state_in    = ST_WR0;
         end
         ST_WR0: begin
            cmd.store_sum = 1'b1;
            cmd.res_sum   = 1'b1;
            cmd.finish    = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_RDDATA: begin
            cmd.res_entry = 1'b1;
            cmd.finish    = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cont_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cont_ff  <= cont_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/core/fsca_dpath.sv @@
// Datapath: table RAM, scan counter, checksum accumulator, result words.
// Depends on fsca_pkg and fsca_ram; steered by fsca_ctrl.
`timescale 1ns / 1ps

module fsca_dpath import fsca_pkg::*; #(
   parameter int TABLE_DEPTH  = 2048,
   parameter int SECTOR_BYTES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fsca_cmd_type         cmd,
   output fsca_stat_type        stat,
   input  logic [START_W-1:0]   data_region_start,
   input  logic [LIMIT_W-1:0]   entries_in_use,
   input  logic [INDEX_W-1:0]   req_index,
   input  logic [ENTRY_W-1:0]   req_value,
   input  logic [LENGTH_W-1:0]  req_length,
   output logic                 rsp_strobe,
   output logic [SECTOR_W-1:0]  rsp_sector,
   output logic                 rsp_full_res,
   output logic [ENTRY_W-1:0]   rsp_entry_value,
   output logic [SUM_W-1:0]     rsp_table_sum
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int LW0 = $clog2(TABLE_DEPTH + 1);
   localparam int LW  = (LW0 > LIMIT_W) ? LW0 : LIMIT_W;

   logic [LW-1:0]       scan_ff, scan_in;
   logic [LW-1:0]       lag_ff, lag_in;
   logic                lag_vld_ff, lag_vld_in;
   logic [SECTOR_W-1:0] cur_ff, cur_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                idx_ok_ff, idx_ok_in;

   logic                strobe_ff;
   logic [SECTOR_W-1:0] sector_ff;
   logic                full_ff;
   logic [ENTRY_W-1:0]  entry_ff;
   logic [SUM_W-1:0]    tsum_ff;

   logic [LW-1:0]       depth_c, limit, start_pt, skip, idx_ext, cur_ext;
   logic                more, idx_ok, cur_ok;
   logic [ENTRY_W-1:0]  len_ext, len_cl;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [ENTRY_W-1:0]  wr_data, rd_data;

   fsca_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign depth_c  = LW'(TABLE_DEPTH);
   assign limit    = (LW'(entries_in_use) > depth_c) ? depth_c : LW'(entries_in_use);
   assign start_pt = (data_region_start == '0) ? LW'(1) : LW'(data_region_start);
   assign more     = (scan_ff < limit);
   assign idx_ext  = LW'(req_index);
   assign cur_ext  = LW'(cur_ff);
   assign idx_ok   = (idx_ext < depth_c);
   assign cur_ok   = (cur_ext < depth_c);
   assign skip     = cmd.skip_cur ? cur_ext : '0;
   assign len_ext  = ENTRY_W'(req_length);
   assign len_cl   = (len_ext > ENTRY_W'(SECTOR_BYTES)) ? ENTRY_W'(SECTOR_BYTES) : len_ext;

   assign stat.clear_last = (scan_ff == LW'(TABLE_DEPTH - 1));
   assign stat.hit        = lag_vld_ff && !rd_data[ENTRY_W-1] && (lag_ff != skip);
   assign stat.done       = !lag_vld_ff && !more;

   // scan address generator; lag_ff tags the word now on rd_data
   always_comb begin
      scan_in    = scan_ff;
      lag_in     = lag_ff;
      lag_vld_in = lag_vld_ff;
      if (cmd.clear_step) begin
         scan_in = scan_ff + 1'b1;
      end else if (cmd.load_start) begin
         scan_in    = start_pt;
         lag_vld_in = 1'b0;
      end else if (cmd.load_one) begin
         scan_in    = LW'(1);
         lag_vld_in = 1'b0;
      end else if (cmd.scan_run) begin
         if (more) begin
            scan_in    = scan_ff + 1'b1;
            lag_in     = scan_ff;
            lag_vld_in = 1'b1;
         end else begin
            lag_vld_in = 1'b0;
         end
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (cmd.accept) begin
         sum_in = '0;
      end else if (cmd.acc_sum && lag_vld_ff) begin
         sum_in = SUM_W'(sum_ff + rd_data[7:0] + rd_data[15:8]);
      end
   end

   assign idx_ok_in = cmd.accept ? idx_ok : idx_ok_ff;
   assign cur_in    = cmd.take_hit ? lag_ff[SECTOR_W-1:0] : cur_ff;

   // single write port: clearing pass, write, end mark, link, checksum store
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = scan_ff[AW-1:0];
      end else if (cmd.do_write) begin
         wr_en   = idx_ok;
         wr_addr = idx_ext[AW-1:0];
         wr_data = req_value;
      end else if (cmd.do_mark) begin
         wr_en   = cur_ok;
         wr_addr = cur_ext[AW-1:0];
         wr_data = USED_BIT | len_cl;
      end else if (cmd.do_link) begin
         wr_en   = cur_ok;
         wr_addr = cur_ext[AW-1:0];
         wr_data = LINK_BITS | ENTRY_W'(lag_ff[SECTOR_W-1:0]);
      end else if (cmd.store_sum) begin
         wr_en   = 1'b1;
         wr_data = {sum_ff, rd_data[7:0]};
      end
   end

   always_comb begin
      if (cmd.rd_index) begin
         rd_addr = idx_ext[AW-1:0];
      end else if (cmd.rd_zero) begin
         rd_addr = '0;
      end else begin
         rd_addr = scan_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         lag_vld_ff <= 1'b0;
         cur_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         scan_ff    <= scan_in;
         lag_vld_ff <= lag_vld_in;
         cur_ff     <= cur_in;
         strobe_ff  <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      lag_ff    <= lag_in;
      sum_ff    <= sum_in;
      idx_ok_ff <= idx_ok_in;
      if (cmd.finish) begin
         sector_ff <= cmd.take_hit ? lag_ff[SECTOR_W-1:0] : '0;
         full_ff   <= cmd.res_full;
         entry_ff  <= (cmd.res_entry && idx_ok_ff) ? rd_data : '0;
         tsum_ff   <= cmd.res_sum ? sum_ff : '0;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_sector      = sector_ff;
   assign rsp_full_res    = full_ff;
   assign rsp_entry_value = entry_ff;
   assign rsp_table_sum   = tsum_ff;

endmodule

@@ rtl/core/fat_sector_chain_allocator_core.sv @@
// Top level of the sector chain allocator: register port, controller, datapath.
// Depends on fsca_pkg, fsca_ctrl, fsca_dpath (and fsca_ram below it).
`timescale 1ns / 1ps

// First-fit allocator over a table of 16-bit entries (bit 15 = used) held in
// a single RAM. Issue a command by raising start while busy is low; the word
// is taken at that edge and busy rises. Every command gives exactly one result
// word on rsp_* marked by a one-cycle rsp_strobe, which cannot be held off:
// capture it when it appears. Begin/continue chain scan one entry per cycle
// through the RAM read port from data_region_start, then again from entry 1,
// over entries below limit = min(entries_in_use, TABLE_DEPTH). Checksum walks
// entries 1..limit-1 then rewrites entry 0. After reset a clearing pass zeroes
// the table, one entry a cycle, with busy high; configuration writes are taken
// throughout. Registers: data_region_start at 0x0, entries_in_use at 0x4;
// only write them while the block is idle.

module fat_sector_chain_allocator_core import fsca_pkg::*; #(
   parameter int TABLE_DEPTH  = 2048,
   parameter int SECTOR_BYTES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // command word
   input  logic                   start,
   output logic                   busy,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [INDEX_W-1:0]     req_index,
   input  logic [ENTRY_W-1:0]     req_value,
   input  logic [LENGTH_W-1:0]    req_length,
   // result word
   output logic                   rsp_strobe,
   output logic [SECTOR_W-1:0]    rsp_sector,
   output logic                   rsp_full_res,
   output logic [ENTRY_W-1:0]     rsp_entry_value,
   output logic [SUM_W-1:0]       rsp_table_sum,
   // register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   fsca_cmd_type       cmd;
   fsca_stat_type      stat;

   logic [START_W-1:0] start_ff, start_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_wr;

   // register port: zero wait states, decode on paddr[2] only
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      start_in = start_ff;
      limit_in = limit_ff;
      if (csr_wr) begin
         case (paddr[2])
            REG_DATA_START:  start_in = pwdata[START_W-1:0];
            REG_ENTRIES_USE: limit_in = pwdata[LIMIT_W-1:0];
            default: begin
               start_in = start_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         limit_ff <= LIMIT_RESET;
      end else begin
         start_ff <= start_in;
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_DATA_START:  prdata = CSR_DATA_W'(start_ff);
         REG_ENTRIES_USE: prdata = CSR_DATA_W'(limit_ff);
         default:         prdata = '0;
      endcase
   end

   fsca_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   fsca_dpath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .data_region_start (start_ff),
      .entries_in_use    (limit_ff),
      .req_index         (req_index),
      .req_value         (req_value),
      .req_length        (req_length),
      .rsp_strobe        (rsp_strobe),
      .rsp_sector        (rsp_sector),
      .rsp_full_res      (rsp_full_res),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_table_sum     (rsp_table_sum)
   );

endmodule

@@ rtl/core/fsca_checker.sv @@
// Port-level checks for the sector chain allocator, bound to the top level.
// Depends on fsca_pkg and fat_sector_chain_allocator_core.
`timescale 1ns / 1ps

module fsca_checker import fsca_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input logic [SECTOR_W-1:0] rsp_sector,
   input logic                rsp_full_res,
   input logic [ENTRY_W-1:0]  rsp_entry_value,
   input logic [SUM_W-1:0]    rsp_table_sum
);

   // an accepted word always raises busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after command accepted");

   // one result per command, never two in a row
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_full_no_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_full_res |-> rsp_sector == '0)
      else $error("full result carries a sector");

   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_entry_value != '0 |->
         rsp_sector == '0 && !rsp_full_res && rsp_table_sum == '0)
      else $error("read result mixed with other fields");

endmodule

bind fat_sector_chain_allocator_core fsca_checker u_fsca_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_sector      (rsp_sector),
   .rsp_full_res    (rsp_full_res),
   .rsp_entry_value (rsp_entry_value),
   .rsp_table_sum   (rsp_table_sum)
);

@@ tb/testbench.sv @@
// Self-checking bench for fat_sector_chain_allocator_core: directed table, then random phases.
// Depends on fsca_pkg and the core RTL only; predicts every result word in place.
`timescale 1ns / 1ps

module testbench;
   import fsca_pkg::*;

   localparam int TABLE_DEPTH  = 2048;
   localparam int SECTOR_BYTES = 1024;

   // spare command codes, no effect on the table
   localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

   // one result word
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic                full;
      logic [ENTRY_W-1:0]  entry;
      logic [SUM_W-1:0]    tbl_sum;
   } alloc_result_type;

   // one row of the directed table; typed rows carry the result read off by hand
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [INDEX_W-1:0]  index;
      logic [ENTRY_W-1:0]  value;
      logic [LENGTH_W-1:0] length;
      logic                typed;
      alloc_result_type    res;
   } stim_row_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      alloc_result_type  res;
   } awaited_type;

   localparam alloc_result_type NO_RES = '0;

   // After reset: start 128, 2048 entries, table clear. Begin lands on 128,
   // continue on 129 and links 128 -> 0xC081; end marks 129 with the length,
   // clamped to a full sector and 0 kept as is.
   localparam int N_DIRECTED = 25;
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{KIND_READ,   11'd0,    16'h0000, 11'd0,    1'b1, NO_RES},
      '{KIND_READ,   11'd2047, 16'h0000, 11'd0,    1'b1, NO_RES},
      '{KIND_SUM,    11'd0,    16'h0000, 11'd0,    1'b1, NO_RES},
      '{KIND_BEGIN,  11'd0,    16'h0000, 11'd0,    1'b1, '{11'd128, 1'b0, 16'h0, 8'h0}},
      '{KIND_CONT,   11'd0,    16'h0000, 11'd0,    1'b1, '{11'd129, 1'b0, 16'h0, 8'h0}},
      '{KIND_END,    11'd0,    16'h0000, 11'd1024, 1'b1, NO_RES},
      '{KIND_READ,   11'd128,  16'h0000, 11'd0,    1'b1, '{11'd0, 1'b0, 16'hC081, 8'h0}},
      '{KIND_READ,   11'd129,  16'h0000, 11'd0,    1'b1, '{11'd0, 1'b0, 16'h8400, 8'h0}},
      '{KIND_WRITE,  11'd2047, 16'hFFFF, 11'd0,    1'b1, NO_RES},
      '{KIND_READ,   11'd2047, 16'h0000, 11'd0,    1'b1, '{11'd0, 1'b0, 16'hFFFF, 8'h0}},
      '{KIND_END,    11'd0,    16'h0000, 11'd0,    1'b1, NO_RES},
      '{KIND_READ,   11'd129,  16'h0000, 11'd0,    1'b1, '{11'd0, 1'b0, 16'h8000, 8'h0}},
      '{KIND_END,    11'd0,    16'h0000, 11'd2047, 1'b1, NO_RES},
      '{KIND_READ,   11'd129,  16'h0000, 11'd0,    1'b1, '{11'd0, 1'b0, 16'h8400, 8'h0}},
      '{KIND_END,    11'd0,    16'h0000, 11'd1,    1'b1, NO_RES},
      '{KIND_READ,   11'd129,  16'h0000, 11'd0,    1'b1, '{11'd0, 1'b0, 16'h8001, 8'h0}},
      '{KIND_SPARE6, 11'd5,    16'hABCD, 11'd7,    1'b1, NO_RES},
      '{KIND_SPARE7, 11'd2047, 16'hFFFF, 11'd2047, 1'b1, NO_RES},
      '{KIND_WRITE,  11'd0,    16'h00FF, 11'd0,    1'b1, NO_RES},
      '{KIND_SUM,    11'd0,    16'h0000, 11'd0,    1'b0, NO_RES},
      '{KIND_READ,   11'd0,    16'h0000, 11'd0,    1'b0, NO_RES},
      '{KIND_WRITE,  11'd130,  16'h8000, 11'd0,    1'b1, NO_RES},
      '{KIND_BEGIN,  11'd0,    16'h0000, 11'd0,    1'b0, NO_RES},
      '{KIND_CONT,   11'd0,    16'h0000, 11'd0,    1'b0, NO_RES},
      '{KIND_SUM,    11'd0,    16'h0000, 11'd0,    1'b0, NO_RES}
   };

   // Register settings for the random phases: start 0 (read as 1) and 2047,
   // limits 0, 1, 2, 2048 and 4095 (saturates). Big limits get few words,
   // since a checksum then walks the whole table.
   localparam int N_PHASES = 9;
   localparam int PHASE_START [N_PHASES] = '{4, 0, 2047, 10, 1, 1, 5, 1023, 3};
   localparam int PHASE_LIMIT [N_PHASES] = '{16, 12, 2048, 2, 0, 1, 4095, 40, 24};
   localparam int PHASE_WORDS [N_PHASES] = '{45, 35, 20, 30, 15, 10, 20, 40, 50};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  start      = 1'b0;
   logic [KIND_W-1:0]     req_kind   = '0;
   logic [INDEX_W-1:0]    req_index  = '0;
   logic [ENTRY_W-1:0]    req_value  = '0;
   logic [LENGTH_W-1:0]   req_length = '0;
   logic                  psel       = 1'b0;
   logic                  penable    = 1'b0;
   logic                  pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr      = '0;
   logic [CSR_DATA_W-1:0] pwdata     = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic [SECTOR_W-1:0]   rsp_sector;
   logic                  rsp_full_res;
   logic [ENTRY_W-1:0]    rsp_entry_value;
   logic [SUM_W-1:0]      rsp_table_sum;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor state: its own copy of the table, chain pointer and registers
   logic [ENTRY_W-1:0]    fat_image [TABLE_DEPTH];
   logic [SECTOR_W-1:0]   chain_tail;
   logic [START_W-1:0]    cfg_start;
   logic [LIMIT_W-1:0]    cfg_limit;

   awaited_type awaited_words [$];
   awaited_type due;
   int unsigned n_errors   = 0;
   int unsigned n_issued   = 0;
   int unsigned n_compared = 0;
   int unsigned n_settings = 0;
   int unsigned burst_left = 0;

   fat_sector_chain_allocator_core #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_index       (req_index),
      .req_value       (req_value),
      .req_length      (req_length),
      .rsp_strobe      (rsp_strobe),
      .rsp_sector      (rsp_sector),
      .rsp_full_res    (rsp_full_res),
      .rsp_entry_value (rsp_entry_value),
      .rsp_table_sum   (rsp_table_sum),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      n_errors++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned search_limit();
      return (cfg_limit < TABLE_DEPTH) ? int'(cfg_limit) : TABLE_DEPTH;
   endfunction

   // first entry at or after 'from' with bit 15 clear, 'skip' excluded
   function automatic logic first_free(input int unsigned from, input int unsigned skip,
                                       output int unsigned hit);
      int unsigned lim;
      lim = search_limit();
      hit = 0;
      for (int unsigned i = from; i < lim; i++) begin
         if (i != skip && !fat_image[i][15]) begin
            hit = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // data region first, then wrap to entry 1; a start of 0 counts as 1
   function automatic logic find_free_sector(input int unsigned skip, output int unsigned hit);
      int unsigned from;
      from = (cfg_start == 0) ? 1 : int'(cfg_start);
      if (first_free(from, skip, hit))
         return 1'b1;
      return first_free(1, skip, hit);
   endfunction

   // applies one command word to the image and gives the result it must produce
   function automatic alloc_result_type predict_alloc(input logic [KIND_W-1:0] kind,
                                                      input logic [INDEX_W-1:0] index,
                                                      input logic [ENTRY_W-1:0] value,
                                                      input logic [LENGTH_W-1:0] length);
      alloc_result_type r;
      int unsigned      hit;
      int unsigned      acc;
      int unsigned      lim;
      int unsigned      len_c;
      r = NO_RES;
      case (kind)
         KIND_WRITE: fat_image[index] = value;
         KIND_BEGIN: begin
            if (find_free_sector(0, hit)) begin
               r.sector   = SECTOR_W'(hit);
               chain_tail = SECTOR_W'(hit);
            end else begin
               r.full = 1'b1;
            end
         end
         KIND_CONT: begin
            if (find_free_sector(chain_tail, hit)) begin
               r.sector              = SECTOR_W'(hit);
               fat_image[chain_tail] = LINK_BITS | ENTRY_W'(hit);
               chain_tail            = SECTOR_W'(hit);
            end else begin
               r.full = 1'b1;
            end
         end
         KIND_END: begin
            len_c = (length > SECTOR_BYTES) ? SECTOR_BYTES : int'(length);
            fat_image[chain_tail] = USED_BIT | ENTRY_W'(len_c);
         end
         KIND_READ: r.entry = fat_image[index];
         KIND_SUM: begin
            lim = search_limit();
            acc = 0;
            for (int unsigned i = 1; i < lim; i++)
               acc += fat_image[i][7:0] + fat_image[i][15:8];
            r.tbl_sum          = SUM_W'(acc);
            fat_image[0][15:8] = SUM_W'(acc);
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Called on a rising edge. Waits the drawn gap, presents the word and holds
   // start until an edge with busy low takes it; returns on that edge with
   // start still high, so a back-to-back word needs no second assignment.
   task automatic issue_cmd(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] index,
                            input logic [ENTRY_W-1:0] value,
                            input logic [LENGTH_W-1:0] length,
                            input logic typed, input alloc_result_type typed_res);
      int unsigned      gap;
      awaited_type      w;
      alloc_result_type model_res;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 18);
         if ($urandom_range(0, 11) == 0)
            burst_left = $urandom_range(8, 20);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_kind   <= kind;
      req_index  <= index;
      req_value  <= value;
      req_length <= length;
      do @(posedge clock); while (busy !== 1'b0);
      model_res = predict_alloc(kind, index, value, length);
      w.kind    = kind;
      w.res     = typed ? typed_res : model_res;
      awaited_words.push_back(w);
      n_issued++;
   endtask

   // drop start and let every awaited word come home; the block then sits idle
   task automatic drain_to_idle();
      start <= 1'b0;
      do @(posedge clock); while (awaited_words.size() != 0 || busy !== 1'b0);
   endtask

   // APB write then read-back of one register; the predictor takes the new value
   task automatic set_register(input logic reg_sel, input logic [CSR_DATA_W-1:0] wdata);
      logic [CSR_DATA_W-1:0] kept;
      kept = (reg_sel == REG_DATA_START) ? (wdata & 32'h7FF) : (wdata & 32'hFFF);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== kept)
         report_mismatch($sformatf("register %0d reads %h, wrote %h", reg_sel, prdata, kept));
      psel    <= 1'b0;
      penable <= 1'b0;
      if (reg_sel == REG_DATA_START)
         cfg_start = wdata[START_W-1:0];
      else
         cfg_limit = wdata[LIMIT_W-1:0];
      n_settings++;
      // bus idle, psel low, before the next transfer
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- random fields

   // mostly inside the searched region so writes and reads steer the allocator
   function automatic logic [INDEX_W-1:0] rand_index();
      int unsigned lim;
      lim = search_limit();
      if ($urandom_range(0, 9) < 7)
         return INDEX_W'($urandom_range(0, (lim > 0) ? lim - 1 : 15));
      return INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
   endfunction

   function automatic logic [ENTRY_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return ENTRY_W'($urandom);
      endcase
   endfunction

   function automatic logic [LENGTH_W-1:0] rand_length();
      if ($urandom_range(0, 1) == 0)
         return LENGTH_W'($urandom_range(1, SECTOR_BYTES));
      return LENGTH_W'($urandom_range(0, 2047));
   endfunction

   // Mostly whole chains (begin, a few links, end) so searches walk a filling
   // table; sometimes entries are freed again, the rest is single stray words.
   task automatic run_random(input int unsigned count);
      int unsigned sent;
      int unsigned links;
      int unsigned n_free;
      logic [KIND_W-1:0] k;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            links = $urandom_range(0, 4);
            issue_cmd(KIND_BEGIN, rand_index(), rand_value(), rand_length(), 1'b0, NO_RES);
            repeat (links)
               issue_cmd(KIND_CONT, rand_index(), rand_value(), rand_length(), 1'b0, NO_RES);
            issue_cmd(KIND_END, rand_index(), rand_value(), rand_length(), 1'b0, NO_RES);
            sent += links + 2;
            if ($urandom_range(0, 9) < 3) begin
               n_free = $urandom_range(1, 3);
               repeat (n_free)
                  issue_cmd(KIND_WRITE, rand_index(), 16'h0000, rand_length(), 1'b0, NO_RES);
               sent += n_free;
            end
         end else begin
            k = ($urandom_range(0, 9) < 4) ? KIND_WRITE : KIND_W'($urandom_range(0, 7));
            issue_cmd(k, rand_index(), rand_value(), rand_length(), 1'b0, NO_RES);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- result check

   // rsp_strobe holds for one cycle only; sample rsp_* on the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_words.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            due = awaited_words.pop_front();
            n_compared++;
            if (rsp_sector !== due.res.sector)
               report_mismatch($sformatf("kind %0d: sector %0d, want %0d",
                                         due.kind, rsp_sector, due.res.sector));
            if (rsp_full_res !== due.res.full)
               report_mismatch($sformatf("kind %0d: full %b, want %b",
                                         due.kind, rsp_full_res, due.res.full));
            if (rsp_entry_value !== due.res.entry)
               report_mismatch($sformatf("kind %0d: entry %h, want %h",
                                         due.kind, rsp_entry_value, due.res.entry));
            if (rsp_table_sum !== due.res.tbl_sum)
               report_mismatch($sformatf("kind %0d: sum %h, want %h",
                                         due.kind, rsp_table_sum, due.res.tbl_sum));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++)
         fat_image[i] = '0;
      chain_tail = '0;
      cfg_start  = START_RESET;
      cfg_limit  = LIMIT_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table on the reset settings; the first word also rides out
      // the clearing pass, as start simply stays up until busy drops
      for (int r = 0; r < N_DIRECTED; r++)
         issue_cmd(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].value,
                   DIRECTED_ROWS[r].length, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);

      // random phases, registers changed only with the block idle; upper
      // pwdata bits are junk the register must drop
      for (int p = 0; p < N_PHASES; p++) begin
         drain_to_idle();
         set_register(REG_DATA_START,
                      {21'($urandom_range(0, 2097151)), 11'(PHASE_START[p])});
         set_register(REG_ENTRIES_USE,
                      {20'($urandom_range(0, 1048575)), 12'(PHASE_LIMIT[p])});
         run_random(PHASE_WORDS[p]);
      end

      drain_to_idle();
      // room for a stray late word: longer than a full double scan
      repeat (4200) @(posedge clock);

      $display("Covered %0d command words (%0d from the directed table), %0d results compared,",
               n_issued, N_DIRECTED, n_compared);
      $display("across %0d register writes with read-back; %0d mismatches.",
               n_settings, n_errors);
      if (n_errors == 0 && awaited_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog. Slowest legal run: ~320 words, each a full double scan of
   // 2048 entries plus the longest drawn gap, plus the clearing pass:
   // about 16 ms. Allow some five times that.
   initial begin
      #80_000_000;
      $display("Timed out with %0d result words outstanding.", awaited_words.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
